// ===== rtl/lph_pkg.sv =====
// Shared types, codes and the key hash for the linear probe hash table.
// No dependencies; lph_front, lph_back, the top level and the testbench import this package.
package lph_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int KEY_W            = 32;
   localparam int VALUE_W          = 32;
   localparam int SIZE_W           = 11;
   localparam int COUNT_OUT_W      = 11;
   localparam int HASH_W           = 32;
   localparam int DIGIT_W          = 4;
   localparam int DIV_STEPS        = HASH_W / DIGIT_W;
   localparam int STATUS_W         = 2;
   localparam int ENTRY_W          = STATUS_W + KEY_W + VALUE_W;
   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd787;
   localparam logic [HASH_W-1:0] FOLD_MASK        = 32'hf000_0000;
   localparam int FOLD_SHIFT       = 24;

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_PUT    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_NOFREE   = 2'd2,
      ST_UNUSED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_LIVE    = 2'd1,
      SLOT_DELETED = 2'd2,
      SLOT_UNUSED  = 2'd3
   } slot_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_READ,
      B_CHECK,
      B_CLEAR,
      B_DONE
   } back_state_type;

   // Shift-and-fold string hash over the key bytes, most significant first
   function automatic logic [HASH_W-1:0] fold_hash(input logic [KEY_W-1:0] key);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] g;
      h = '0;
      for (int i = KEY_W / 8 - 1; i >= 0; i--) begin
         h = (h << 4) + HASH_W'(key[i*8 +: 8]);
         g = h & FOLD_MASK;
         if (g != '0) begin
            h = (h ^ (g >> FOLD_SHIFT)) ^ g;
         end
      end
      return h;
   endfunction

endpackage

// ===== rtl/lph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lph_front.sv =====
// Front end: accepts items, hashes the key and reduces it modulo the table size.
// Uses lph_pkg; feeds the item queue.
module lph_front
   import lph_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1),
   parameter int QW       = 2 + KEY_W + VALUE_W + CW + AW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [CW-1:0]      eff_size,
   input  logic               init_busy,
   output logic               q_push,
   output logic [QW-1:0]      q_data,
   input  logic               q_full
);

   front_state_type     state_ff, state_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [AW-1:0]       rem_ff, rem_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [CW-1:0]       size_ff, size_in;
   logic                accept;

   assign req_stall = (state_ff != F_IDLE) || init_busy;
   assign accept    = req_valid && !req_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = (op_type'(req_operation) == OP_CLEAR) ? F_PUSH : F_DIV;
            end
         end
         F_DIV: begin
            if (cnt_ff == 3'(DIV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Datapath: capture item, then one hash digit of long division a cycle
   always_comb begin
      logic [AW:0] t;
      hash_in = hash_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      key_in  = key_ff;
      val_in  = val_ff;
      size_in = size_ff;
      q_push  = 1'b0;
      t       = '0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               op_in   = req_operation;
               key_in  = req_key;
               val_in  = req_value;
               size_in = eff_size;
               hash_in = fold_hash(req_key);
               rem_in  = '0;
               cnt_in  = '0;
            end
         end
         F_DIV: begin
            for (int i = 0; i < DIGIT_W; i++) begin
               t = {rem_in, hash_in[HASH_W-1]};
               hash_in = hash_in << 1;
               if (t >= (AW + 1)'(size_ff)) begin
                  t = t - (AW + 1)'(size_ff);
               end
               rem_in = t[AW-1:0];
            end
            cnt_in = cnt_ff + 3'd1;
         end
         F_PUSH: begin
            q_push = !q_full;
         end
         default: ;
      endcase
   end

   assign q_data = {op_ff, key_ff, val_ff, size_ff, rem_ff};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      rem_ff  <= rem_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      size_ff <= size_in;
   end

endmodule

// ===== rtl/lph_queue.sv =====
// Two-entry item queue between the front end and the probe engine.
// Depends on nothing.
module lph_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = data_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/lph_back.sv =====
// Probe engine: walks slots one read at a time, updates the table and counts,
// and holds the result register. Uses lph_pkg and lph_ram.
module lph_back
   import lph_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1),
   parameter int QW       = 2 + KEY_W + VALUE_W + CW + AW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  logic [QW-1:0]          q_data,
   output logic                   q_pop,
   output logic                   init_busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_found,
   output logic [VALUE_W-1:0]     rsp_read_value,
   output logic [1:0]             rsp_status,
   output logic                   rsp_grow_needed,
   output logic [COUNT_OUT_W-1:0] rsp_live_count
);

   back_state_type      state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       loc_ff, loc_in;
   logic [CW-1:0]       n_ff, n_in;
   logic                have_del_ff, have_del_in;
   logic [AW-1:0]       del_loc_ff, del_loc_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [CW-1:0]       live_ff, live_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [CW-1:0]       size_ff, size_in;
   logic                res_found_ff, res_found_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_grow_ff, rsp_grow_in;
   logic [COUNT_OUT_W-1:0] rsp_live_ff, rsp_live_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_W-1:0]  rd_data;

   logic [1:0]          q_op;
   logic [KEY_W-1:0]    q_key;
   logic [VALUE_W-1:0]  q_val;
   logic [CW-1:0]       q_size;
   logic [AW-1:0]       q_loc;

   slot_type            slot_st;
   logic [KEY_W-1:0]    slot_key;
   logic [VALUE_W-1:0]  slot_val;
   logic                key_hit;
   logic [CW-1:0]       n_next;
   logic                sweep_end;
   logic                probe_stop;
   logic                clr_last;
   logic                out_free;
   logic [AW-1:0]       loc_step;
   logic [31:0]         live_wide;

   assign {q_op, q_key, q_val, q_size, q_loc} = q_data;

   lph_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (loc_ff),
      .rd_data (rd_data)
   );

   // Decode the slot just read and the probe position
   assign slot_st    = slot_type'(rd_data[ENTRY_W-1 -: STATUS_W]);
   assign slot_key   = rd_data[VALUE_W +: KEY_W];
   assign slot_val   = rd_data[VALUE_W-1:0];
   assign key_hit    = (slot_st == SLOT_LIVE) && (slot_key == key_ff);
   assign n_next     = n_ff + CW'(1);
   assign sweep_end  = (n_next == size_ff);
   assign probe_stop = (slot_st == SLOT_EMPTY) || key_hit || sweep_end;
   assign loc_step   = ((CW'(loc_ff) + CW'(1)) == size_ff) ? '0 : loc_ff + AW'(1);
   assign clr_last   = (clr_ff == AW'(CAPACITY - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign init_busy  = (state_ff == B_INIT);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_INIT:  if (clr_last) state_in = B_IDLE;
         B_IDLE: begin
            if (!q_empty) begin
               state_in = (op_type'(q_op) == OP_CLEAR) ? B_CLEAR : B_READ;
            end
         end
         B_READ:  state_in = B_CHECK;
         B_CHECK: state_in = probe_stop ? B_DONE : B_READ;
         B_CLEAR: if (clr_last) state_in = B_DONE;
         B_DONE:  if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Datapath and table writes
   always_comb begin
      logic          use_del;
      logic [AW-1:0] del_pick;
      clr_in        = clr_ff;
      loc_in        = loc_ff;
      n_in          = n_ff;
      have_del_in   = have_del_ff;
      del_loc_in    = del_loc_ff;
      used_in       = used_ff;
      live_in       = live_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      size_in       = size_ff;
      res_found_in  = res_found_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = loc_ff;
      wr_data       = {SLOT_LIVE, key_ff, val_ff};
      use_del       = have_del_ff || (slot_st == SLOT_DELETED);
      del_pick      = have_del_ff ? del_loc_ff : loc_ff;
      case (state_ff)
         B_INIT, B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {SLOT_EMPTY, {(KEY_W + VALUE_W){1'b0}}};
            clr_in  = clr_ff + AW'(1);
            used_in = '0;
            live_in = '0;
         end
         B_IDLE: begin
            if (!q_empty) begin
               q_pop         = 1'b1;
               op_in         = q_op;
               key_in        = q_key;
               val_in        = q_val;
               size_in       = q_size;
               loc_in        = q_loc;
               n_in          = '0;
               have_del_in   = 1'b0;
               clr_in        = '0;
               res_found_in  = 1'b0;
               res_value_in  = '0;
               res_status_in = ST_OK;
            end
         end
         B_CHECK: begin
            if (op_type'(op_ff) == OP_PUT) begin
               if (slot_st == SLOT_EMPTY) begin
                  // Take the first tombstone seen, else this empty slot
                  wr_en   = 1'b1;
                  wr_addr = have_del_ff ? del_loc_ff : loc_ff;
                  live_in = live_ff + CW'(1);
                  if (!have_del_ff) used_in = used_ff + CW'(1);
               end else if (key_hit) begin
                  wr_en = 1'b1;
               end else begin
                  if ((slot_st == SLOT_DELETED) && !have_del_ff) begin
                     have_del_in = 1'b1;
                     del_loc_in  = loc_ff;
                  end
                  if (sweep_end) begin
                     if (use_del) begin
                        wr_en   = 1'b1;
                        wr_addr = del_pick;
                        live_in = live_ff + CW'(1);
                     end else begin
                        res_status_in = ST_NOFREE;
                     end
                  end
               end
            end else begin
               if (slot_st == SLOT_EMPTY) begin
                  res_status_in = ST_NOTFOUND;
               end else if (key_hit) begin
                  res_found_in = 1'b1;
                  if (op_type'(op_ff) == OP_GET) begin
                     res_value_in = slot_val;
                  end else begin
                     // Leave a tombstone in place of the entry
                     wr_en   = 1'b1;
                     wr_data = {SLOT_DELETED, slot_key, slot_val};
                     if (live_ff != '0) live_in = live_ff - CW'(1);
                  end
               end else if (sweep_end) begin
                  res_status_in = ST_NOTFOUND;
               end
            end
            if (!probe_stop) begin
               loc_in = loc_step;
               n_in   = n_next;
            end
         end
         default: ;
      endcase
   end

   // Result register: load when done, drop when taken
   assign live_wide = 32'(live_ff);
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grow_in   = rsp_grow_ff;
      rsp_live_in   = rsp_live_ff;
      if ((state_ff == B_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = res_found_ff;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
         rsp_grow_in   = (32'(used_ff) * 32'd4) > (32'(size_ff) * 32'd3);
         rsp_live_in   = live_wide[COUNT_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         clr_ff       <= '0;
         used_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      loc_ff        <= loc_in;
      n_ff          <= n_in;
      have_del_ff   <= have_del_in;
      del_loc_ff    <= del_loc_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      size_ff       <= size_in;
      res_found_ff  <= res_found_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grow_ff   <= rsp_grow_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_grow_needed = rsp_grow_ff;
   assign rsp_live_count  = rsp_live_ff;

`ifndef NO_ASSERTIONS
   a_live_le_used: assert property (@(posedge clock) disable iff (reset)
      live_ff <= used_ff) else $error("live count exceeds used count");
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !q_pop) else $error("item taken during reset sweep");
   a_result_after_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == B_DONE))
      else $error("result loaded outside done state");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_status_ff == ST_OK))
      else $error("found with error status");
`endif

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table: size register, front end,
// item queue and probe engine. Uses lph_pkg, lph_front, lph_queue, lph_back.
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      operation, key, value
//   rsp_      out        valid / stall      found, read_value, status, grow_needed, live_count
//   csr_      in         valid / ready      table_size
//
// Front end: accept, reduce modulo (4 hash bits a cycle), push; a clear skips the reduction.
// Probe engine: take the item from the queue, then a RAM read and a check for each slot
// probed, then load the result register once the previous result has been taken.
// A clear sweeps every slot of the slot RAM, one slot a cycle.
// After reset the same sweep runs with req_stall high.
// The front end takes items while the engine probes; rsp_stall stalls it only via the queue.
module linear_probe_hash_table
   import lph_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [KEY_W-1:0]       req_key,
   input  logic [VALUE_W-1:0]     req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_found,
   output logic [VALUE_W-1:0]     rsp_read_value,
   output logic [1:0]             rsp_status,
   output logic                   rsp_grow_needed,
   output logic [COUNT_OUT_W-1:0] rsp_live_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SIZE_W-1:0]      csr_table_size
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int QW = 2 + KEY_W + VALUE_W + CW + AW;

   logic [SIZE_W-1:0] table_size_ff, table_size_in;
   logic [CW-1:0]     eff_size;
   logic              init_busy;
   logic              q_push, q_full, q_pop, q_empty;
   logic [QW-1:0]     q_push_data, q_pop_data;

   assign csr_ready = 1'b1;

   // Hold the size register
   always_comb begin
      table_size_in = (csr_valid && csr_ready) ? csr_table_size : table_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // Clamp the size to one through CAPACITY
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = CW'(1);
      end else if (32'(table_size_ff) > 32'(CAPACITY)) begin
         eff_size = CW'(CAPACITY);
      end else begin
         eff_size = CW'(table_size_ff);
      end
   end

   lph_front #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW),
      .QW       (QW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key       (req_key),
      .req_value     (req_value),
      .eff_size      (eff_size),
      .init_busy     (init_busy),
      .q_push        (q_push),
      .q_data        (q_push_data),
      .q_full        (q_full)
   );

   lph_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   lph_back #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW),
      .QW       (QW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_pop_data),
      .q_pop           (q_pop),
      .init_busy       (init_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_grow_needed (rsp_grow_needed),
      .rsp_live_count  (rsp_live_count)
   );

endmodule

// ===== dv/linear_probe_hash_table_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linear_probe_hash_table: drives get, put, remove and clear
// items under random idling and stalls, predicts each result and checks it. Uses lph_pkg.
module linear_probe_hash_table_tb;
   import lph_pkg::*;

   localparam int SLOTS      = 1024;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [VALUE_W-1:0] value;
   } table_op_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      status_type         status;
      logic               grow_needed;
      logic [10:0]        live_count;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = '0;
   logic [KEY_W-1:0] req_key = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [VALUE_W-1:0] rsp_read_value;
   logic [1:0] rsp_status;
   logic rsp_grow_needed;
   logic [COUNT_OUT_W-1:0] rsp_live_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SIZE_W-1:0] csr_table_size = '0;

   // shadow copy of the table
   logic [KEY_W-1:0]   shadow_key [SLOTS];
   logic [VALUE_W-1:0] shadow_value [SLOTS];
   slot_type           shadow_status [SLOTS];
   int unsigned        used_cnt;
   int unsigned        live_cnt;
   logic [SIZE_W-1:0]  size_reg;

   table_op_type    pending_ops[$];
   table_reply_type expected_replies[$];
   int         mismatches = 0;
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         quiet_cycles = 0;
   logic [KEY_W-1:0] key_pool[$];

   linear_probe_hash_table DUT (.*);

   always #5 clock = ~clock;

   function automatic logic [31:0] key_hash(input logic [31:0] k);
      logic [31:0] h;
      logic [31:0] g;
      h = '0;
      for (int i = 3; i >= 0; i--) begin
         h = (h << 4) + {24'd0, k[i*8 +: 8]};
         g = h & 32'hf000_0000;
         if (g != 0) h = (h ^ (g >> 24)) ^ g;
      end
      return h;
   endfunction

   function automatic int unsigned active_size();
      if (size_reg == 0) return 1;
      if (size_reg > SLOTS) return SLOTS;
      return size_reg;
   endfunction

   // Apply one item to the shadow table and return its reply
   function automatic table_reply_type table_apply(input table_op_type it);
      table_reply_type r;
      int unsigned sz;
      int unsigned loc;
      int unsigned del_loc;
      bit have_del;
      bit placed;
      sz = active_size();
      loc = key_hash(it.key) % sz;
      del_loc = 0;
      have_del = 0;
      placed = 0;
      r = '0;
      r.status = ST_OK;
      if (it.op == OP_CLEAR) begin
         foreach (shadow_status[i]) shadow_status[i] = SLOT_EMPTY;
         used_cnt = 0;
         live_cnt = 0;
      end else if (it.op == OP_PUT) begin
         for (int n = 0; n < sz && !placed; n++) begin
            if (shadow_status[loc] == SLOT_EMPTY) begin
               if (have_del) loc = del_loc;
               else used_cnt++;
               shadow_status[loc] = SLOT_LIVE;
               live_cnt++;
               shadow_key[loc] = it.key;
               shadow_value[loc] = it.value;
               placed = 1;
            end else if (shadow_status[loc] == SLOT_DELETED) begin
               if (!have_del) begin
                  have_del = 1;
                  del_loc = loc;
               end
            end else if (shadow_key[loc] == it.key) begin
               shadow_value[loc] = it.value;
               placed = 1;
            end
            if (!placed) loc = (loc + 1 == sz) ? 0 : loc + 1;
         end
         if (!placed) begin
            if (have_del) begin
               shadow_status[del_loc] = SLOT_LIVE;
               shadow_key[del_loc] = it.key;
               shadow_value[del_loc] = it.value;
               live_cnt++;
            end else begin
               r.status = ST_NOFREE;
            end
         end
      end else begin
         r.status = ST_NOTFOUND;
         for (int n = 0; n < sz; n++) begin
            if (shadow_status[loc] == SLOT_EMPTY) break;
            if (shadow_status[loc] == SLOT_LIVE && shadow_key[loc] == it.key) begin
               r.found = 1'b1;
               r.status = ST_OK;
               if (it.op == OP_GET) begin
                  r.read_value = shadow_value[loc];
               end else begin
                  shadow_status[loc] = SLOT_DELETED;
                  if (live_cnt > 0) live_cnt--;
               end
               break;
            end
            loc = (loc + 1 == sz) ? 0 : loc + 1;
         end
      end
      r.grow_needed = (used_cnt * 4 > sz * 3);
      r.live_count = live_cnt[10:0];
      return r;
   endfunction

   // Driver: present queued items, predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_replies.push_back(table_apply(
               '{op: op_type'(req_operation), key: req_key, value: req_value}));
         end
         if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_operation <= pending_ops[0].op;
            req_key <= pending_ops[0].key;
            req_value <= pending_ops[0].value;
            void'(pending_ops.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted reply with the oldest expectation
   always @(posedge clock) begin
      table_reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected reply at %0t", $realtime);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_found !== want.found || rsp_read_value !== want.read_value ||
                   rsp_status !== want.status || rsp_grow_needed !== want.grow_needed ||
                   rsp_live_count !== want.live_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch at %0t: expected f%0b v%h s%0d g%0b l%0d, ",
                               "got f%0b v%h s%0d g%0b l%0d"},
                        $realtime, want.found, want.read_value, want.status, want.grow_needed,
                        want.live_count, rsp_found, rsp_read_value, rsp_status,
                        rsp_grow_needed, rsp_live_count);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("linear_probe_hash_table_tb: errors");
         $finish;
      end
   end

   task automatic drain();
      @(negedge clock);
      while (pending_ops.size() > 0 || req_valid || expected_replies.size() > 0)
         @(negedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_table_size <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      size_reg = v;
   endtask

   task automatic add_op(input op_type op, input logic [31:0] k, input logic [31:0] v);
      pending_ops.push_back('{op: op, key: k, value: v});
   endtask

   // Mostly keys from a small pool so that hits, overwrites and full tables occur
   task automatic add_random(input int count);
      int pick;
      logic [31:0] k;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         k = ($urandom_range(9) == 0) ? $urandom()
                                      : key_pool[$urandom_range(key_pool.size() - 1)];
         if (pick < 2) add_op(OP_CLEAR, $urandom(), $urandom());
         else if (pick < 47) add_op(OP_PUT, k, $urandom());
         else if (pick < 77) add_op(OP_GET, k, $urandom());
         else add_op(OP_REMOVE, k, $urandom());
      end
   endtask

   initial begin
      logic [SIZE_W-1:0] sizes [10];
      int pool_n;
      sizes = '{11'd0, 11'd1, 11'd7, 11'd13, 11'd2047, 11'd31, 11'd1024, 11'd5, 11'd61, 11'd1000};
      foreach (shadow_status[i]) shadow_status[i] = SLOT_EMPTY;
      foreach (shadow_key[i]) shadow_key[i] = '0;
      foreach (shadow_value[i]) shadow_value[i] = '0;
      used_cnt = 0;
      live_cnt = 0;
      size_reg = TABLE_SIZE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: misses on an empty table, extremes, overwrite, tombstone reuse, clear
      add_op(OP_GET, 32'h0, 32'h0);
      add_op(OP_REMOVE, 32'hffff_ffff, 32'h0);
      add_op(OP_PUT, 32'h0, 32'h0);
      add_op(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
      add_op(OP_PUT, 32'h1234_5678, 32'hdead_beef);
      add_op(OP_GET, 32'h0, 32'h1);
      add_op(OP_GET, 32'hffff_ffff, 32'h0);
      add_op(OP_PUT, 32'hffff_ffff, 32'h5555_aaaa);
      add_op(OP_GET, 32'hffff_ffff, 32'h0);
      add_op(OP_REMOVE, 32'h1234_5678, 32'h0);
      add_op(OP_GET, 32'h1234_5678, 32'h0);
      add_op(OP_REMOVE, 32'h1234_5678, 32'h0);
      add_op(OP_PUT, 32'h1234_5678, 32'h0bad_f00d);
      add_op(OP_GET, 32'h1234_5678, 32'h0);
      add_op(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
      add_op(OP_GET, 32'h0, 32'h0);
      add_op(OP_PUT, 32'h8000_0001, 32'h0000_0001);
      drain();

      for (int p = 0; p < 10; p++) begin
         write_size(sizes[p]);
         // pick the idling pattern for this phase
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         pool_n = 2 * active_size() + 2;
         if (pool_n > 48) pool_n = 48;
         key_pool.delete();
         for (int i = 0; i < pool_n; i++) key_pool.push_back($urandom());
         // hold the sender until every reply of the first half is back
         add_random(85);
         drain();
         add_random(85);
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_replies.size() == 0)
         $display("linear_probe_hash_table_tb: clean");
      else
         $display("linear_probe_hash_table_tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lph_pkg.sv
rtl/lph_ram.sv
rtl/lph_front.sv
rtl/lph_queue.sv
rtl/lph_back.sv
rtl/linear_probe_hash_table.sv
dv/linear_probe_hash_table_tb.sv
